@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clk edge outside reset.
`define PPBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Plain condition that must hold on every edge outside reset.
`define PPBR_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define PPBR_ASSERT(lbl, prop, msg)
`define PPBR_CHECK(lbl, cond, msg)
`endif

`endif

@@ hdl/ppbr_pkg.sv @@
package ppbr_pkg;

  localparam int MAX_X_POINTS = 64;
  localparam int MAX_Y_POINTS = 64;
  localparam int CORDIC_STEPS = 16;

  localparam int X_IDX_W   = $clog2(MAX_X_POINTS);
  localparam int Y_IDX_W   = $clog2(MAX_Y_POINTS);
  localparam int CNT_W     = $clog2(((MAX_X_POINTS > MAX_Y_POINTS) ?
                                     MAX_X_POINTS : MAX_Y_POINTS) + 1);
  localparam int GRID_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GRID_AW   = $clog2(GRID_DEPTH);
  localparam int STEP_W    = $clog2(CORDIC_STEPS);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;

  // Fixed-point widths
  localparam int GAIN_Q16 = 39797;
  localparam int VEC_W    = 35;   // Q8.24 rotation vector with gain headroom
  localparam int ANG_W    = 34;   // residual angle, 2^-32 turn units
  localparam int PT_W     = 18;   // Cartesian point, Q8.8 plus headroom
  localparam int NUM_W    = 50;   // weighted sample sum
  localparam int DEN_W    = 32;   // area or length
  localparam int DCNT_W   = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    CMD_LOAD_X    = 2'd0,
    CMD_LOAD_Y    = 2'd1,
    CMD_LOAD_GRID = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_POINTS_USED = 1'b0,
    REG_Y_POINTS_USED = 1'b1
  } reg_idx_t;

  localparam logic [1:0] KIND_BILINEAR = 2'd0;
  localparam logic [1:0] KIND_ON_X     = 2'd1;
  localparam logic [1:0] KIND_ON_Y     = 2'd2;
  localparam logic [1:0] KIND_CORNER   = 2'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  // Rotation unit result handed to the sequencer
  typedef struct packed {
    logic                   done;
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
  } cordic_res_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/ppbr_if.sv @@
// Request channel: commands and queries
interface ppbr_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [5:0]         x_index;
  logic [5:0]         y_index;
  logic signed [15:0] load_value;
  logic [15:0]        radius;
  logic [15:0]        angle;

  modport source(output valid, cmd, x_index, y_index, load_value, radius, angle,
                 input ready);
  modport sink(input valid, cmd, x_index, y_index, load_value, radius, angle,
               output ready);
endinterface

// Response channel: one result per request
interface ppbr_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic [1:0]         case_kind;
  logic               status;

  modport source(output valid, value, case_kind, status, input ready);
  modport sink(input valid, value, case_kind, status, output ready);
endinterface

@@ hdl/ppbr_ram.sv @@
// Simple dual-port RAM, one write and one registered read
module ppbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ppbr_cordic.sv @@
// Rotation-mode CORDIC, one micro-rotation per cycle
module ppbr_cordic import ppbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] radius,
  input  logic [15:0] angle,
  output cordic_res_t res
);

  logic                    busy;
  logic                    done;
  logic [STEP_W-1:0]       step;
  logic [1:0]              quad;
  logic signed [VEC_W-1:0] x;
  logic signed [VEC_W-1:0] y;
  logic signed [ANG_W-1:0] z;

  logic [15:0]             ang_rnd;
  logic [1:0]              quad_next;
  logic [15:0]             resid;
  logic [31:0]             x_start;
  logic signed [VEC_W-1:0] x_sh;
  logic signed [VEC_W-1:0] y_sh;
  logic signed [ANG_W-1:0] atan_v;
  logic signed [VEC_W-1:0] xr;
  logic signed [VEC_W-1:0] yr;
  logic signed [VEC_W-1:0] xr_rnd;
  logic signed [VEC_W-1:0] yr_rnd;

  // Nearest quarter turn and the residual left for CORDIC
  always_comb begin
    ang_rnd   = angle + 16'h2000;
    quad_next = ang_rnd[15:14];
    resid     = angle - {quad_next, 14'b0};
    x_start   = {16'b0, radius} * 32'(GAIN_Q16);
  end

  always_comb begin
    x_sh   = x >>> step;
    y_sh   = y >>> step;
    atan_v = signed'({{(ANG_W-30){1'b0}}, atan_turn(5'(step))});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Vector datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quad <= quad_next;
      x    <= signed'({{(VEC_W-32){1'b0}}, x_start});
      y    <= '0;
      z    <= signed'({{(ANG_W-32){resid[15]}}, resid, 16'b0});
    end else if (busy) begin
      if (!z[ANG_W-1]) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atan_v;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atan_v;
      end
    end
  end

  // Exact quarter turns, then round to Q8.8
  always_comb begin
    case (quad)
      2'd1:    begin xr = -y; yr = x;  end
      2'd2:    begin xr = -x; yr = -y; end
      2'd3:    begin xr = y;  yr = -x; end
      default: begin xr = x;  yr = y;  end
    endcase
    xr_rnd = xr + VEC_W'(32768);
    yr_rnd = yr + VEC_W'(32768);
    res.done = done;
    res.px   = xr_rnd[16 +: PT_W];
    res.py   = yr_rnd[16 +: PT_W];
  end

endmodule

@@ hdl/polar_point_bilinear_resample_unit.sv @@
// Channel | Dir | Transaction
// req     | in  | cmd, x_index, y_index, load_value, radius, angle
// rsp     | out | value, case_kind, status
// cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// Loads write their table on the accept cycle. With L = max(nx, ny), a query holds the block
// through CORDIC, an L-entry axis scan, setup, four grid reads, MAC, divide and a handoff.
// A point outside the grid skips the arithmetic.
// Reset (rst, synchronous) clears control and sets both point counts to 1.
// A held result in the output register blocks only the next transaction.
`include "assert_macros.svh"

module polar_point_bilinear_resample_unit import ppbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  ppbr_req_if.sink             req,
  ppbr_rsp_if.source           rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CORDIC = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_SETUP  = 8'b0000_1000,
    S_FETCH  = 8'b0001_0000,
    S_MAC    = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] x_points_used;
  logic [CFG_W-1:0] y_points_used;
  logic [CNT_W-1:0] nx;
  logic [CNT_W-1:0] ny;
  logic [CNT_W-1:0] scan_len;

  logic accept;
  logic slot_free;
  logic load_out;

  // Output register
  logic              o_valid;
  logic signed [15:0] o_value;
  logic [1:0]        o_kind;
  logic              o_status;
  logic signed [15:0] res_value;
  logic [1:0]        res_kind;
  logic              res_status;

  // Query point
  cordic_res_t            cres;
  logic signed [PT_W-1:0] px;
  logic signed [PT_W-1:0] py;

  // Axis scan
  logic [CNT_W-1:0]       scan_cnt;
  logic                   rd_pend;
  logic [CNT_W-1:0]       rd_idx;
  logic [X_IDX_W-1:0]     xl_idx, xh_idx;
  logic [Y_IDX_W-1:0]     yl_idx, yh_idx;
  logic signed [15:0]     xl_val, xh_val, yl_val, yh_val;
  logic                   xl_ok, xh_ok, yl_ok, yh_ok;
  logic signed [15:0]     xv, yv;
  logic signed [PT_W-1:0] xv_ext, yv_ext;
  logic signed [PT_W-1:0] xl_ext, xh_ext, yl_ext, yh_ext;

  // Interpolation
  logic signed [PT_W-1:0] xa, xb, xd, ya, yb, yd;
  logic [15:0]            fx_h, fx_l, fx_d, fy_h, fy_l, fy_d;
  logic [2:0]             step_cnt;
  logic signed [15:0]     corner [4];
  logic [31:0]            w;
  logic signed [15:0]     s_reg;
  logic signed [48:0]     prod;
  logic signed [NUM_W-1:0] acc;
  logic [DEN_W-1:0]       den;
  logic [15:0]            fa, fb;

  // Divider
  logic [DCNT_W-1:0]      div_cnt;
  logic                   neg;
  logic [NUM_W-1:0]       dvd;
  logic [DEN_W-1:0]       rem;
  logic [DEN_W:0]         rem_sh;
  logic [NUM_W-1:0]       acc_mag;

  // RAM ports
  logic                   xa_we, ya_we, g_we;
  logic [X_IDX_W-1:0]     xa_waddr, xa_raddr;
  logic [Y_IDX_W-1:0]     ya_waddr, ya_raddr;
  logic [GRID_AW-1:0]     g_waddr, g_raddr;
  logic [15:0]            xa_rdata, ya_rdata, g_rdata;
  logic [X_IDX_W-1:0]     g_xsel;
  logic [Y_IDX_W-1:0]     g_ysel;

  assign slot_free = !o_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;
  assign load_out  = (accept && (req.cmd != CMD_QUERY)) ||
                     ((state == S_DONE) && slot_free);

  assign rsp.valid     = o_valid;
  assign rsp.value     = o_value;
  assign rsp.case_kind = o_kind;
  assign rsp.status    = o_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_points_used <= CFG_W'(1);
      y_points_used <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_POINTS_USED: x_points_used <= cfg_data;
        REG_Y_POINTS_USED: y_points_used <= cfg_data;
        default: ;
      endcase
    end
  end

  // Count clamp
  always_comb begin
    nx = (32'(x_points_used) > MAX_X_POINTS) ? CNT_W'(MAX_X_POINTS)
                                             : CNT_W'(x_points_used);
    ny = (32'(y_points_used) > MAX_Y_POINTS) ? CNT_W'(MAX_Y_POINTS)
                                             : CNT_W'(y_points_used);
    scan_len = (nx > ny) ? nx : ny;
  end

  // Table writes happen on the accept cycle of a load
  always_comb begin
    xa_we    = accept && (req.cmd == CMD_LOAD_X) && (32'(req.x_index) < MAX_X_POINTS);
    ya_we    = accept && (req.cmd == CMD_LOAD_Y) && (32'(req.y_index) < MAX_Y_POINTS);
    g_we     = accept && (req.cmd == CMD_LOAD_GRID) &&
               (32'(req.x_index) < MAX_X_POINTS) && (32'(req.y_index) < MAX_Y_POINTS);
    xa_waddr = X_IDX_W'(req.x_index);
    ya_waddr = Y_IDX_W'(req.y_index);
    g_waddr  = GRID_AW'(32'(req.x_index) * MAX_Y_POINTS + 32'(req.y_index));
    xa_raddr = scan_cnt[X_IDX_W-1:0];
    ya_raddr = scan_cnt[Y_IDX_W-1:0];
    g_xsel   = step_cnt[0] ? xl_idx : xh_idx;
    g_ysel   = step_cnt[1] ? yl_idx : yh_idx;
    g_raddr  = GRID_AW'(32'(g_xsel) * MAX_Y_POINTS + 32'(g_ysel));
  end

  ppbr_ram #(.WIDTH(16), .DEPTH(MAX_X_POINTS)) u_x_axis (
    .clk(clk), .we(xa_we), .waddr(xa_waddr), .wdata(req.load_value),
    .raddr(xa_raddr), .rdata(xa_rdata)
  );

  ppbr_ram #(.WIDTH(16), .DEPTH(MAX_Y_POINTS)) u_y_axis (
    .clk(clk), .we(ya_we), .waddr(ya_waddr), .wdata(req.load_value),
    .raddr(ya_raddr), .rdata(ya_rdata)
  );

  ppbr_ram #(.WIDTH(16), .DEPTH(GRID_DEPTH)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(req.load_value),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  ppbr_cordic u_cordic (
    .clk(clk), .rst(rst),
    .start(accept && (req.cmd == CMD_QUERY)),
    .radius(req.radius), .angle(req.angle),
    .res(cres)
  );

  // Scan compare values
  always_comb begin
    xv     = signed'(xa_rdata);
    yv     = signed'(ya_rdata);
    xv_ext = PT_W'(xv);
    yv_ext = PT_W'(yv);
    xl_ext = PT_W'(xl_val);
    xh_ext = PT_W'(xh_val);
    yl_ext = PT_W'(yl_val);
    yh_ext = PT_W'(yh_val);
  end

  // Interpolation factors
  always_comb begin
    xa = px - xl_ext;
    xb = xh_ext - px;
    xd = xh_ext - xl_ext;
    ya = py - yl_ext;
    yb = yh_ext - py;
    yd = yh_ext - yl_ext;
    fa = step_cnt[0] ? fx_l : fx_h;
    fb = step_cnt[1] ? fy_l : fy_h;
    acc_mag = acc[NUM_W-1] ? NUM_W'(-acc) : NUM_W'(acc);
    rem_sh  = {rem, dvd[NUM_W-1]};
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (req.cmd == CMD_QUERY)) begin
            state <= S_CORDIC;
          end
        end

        S_CORDIC: begin
          if (cres.done) begin
            px       <= cres.px;
            py       <= cres.py;
            scan_cnt <= '0;
            rd_pend  <= 1'b0;
            xl_ok    <= 1'b0;
            xh_ok    <= 1'b0;
            yl_ok    <= 1'b0;
            yh_ok    <= 1'b0;
            state    <= S_SCAN;
          end
        end

        // One entry of each axis table per cycle
        S_SCAN: begin
          if (scan_cnt < scan_len) begin
            rd_pend  <= 1'b1;
            rd_idx   <= scan_cnt;
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= S_SETUP;
            end
          end
          if (rd_pend && (rd_idx < nx)) begin
            if ((xv_ext <= px) && (!xl_ok || (xv > xl_val))) begin
              xl_idx <= rd_idx[X_IDX_W-1:0];
              xl_val <= xv;
              xl_ok  <= 1'b1;
            end
            if ((xv_ext >= px) && (!xh_ok || (xv < xh_val))) begin
              xh_idx <= rd_idx[X_IDX_W-1:0];
              xh_val <= xv;
              xh_ok  <= 1'b1;
            end
          end
          if (rd_pend && (rd_idx < ny)) begin
            if ((yv_ext <= py) && (!yl_ok || (yv > yl_val))) begin
              yl_idx <= rd_idx[Y_IDX_W-1:0];
              yl_val <= yv;
              yl_ok  <= 1'b1;
            end
            if ((yv_ext >= py) && (!yh_ok || (yv < yh_val))) begin
              yh_idx <= rd_idx[Y_IDX_W-1:0];
              yh_val <= yv;
              yh_ok  <= 1'b1;
            end
          end
        end

        // Case selection and per-axis weights
        S_SETUP: begin
          step_cnt <= '0;
          if (!(xl_ok && xh_ok && yl_ok && yh_ok)) begin
            res_value  <= '0;
            res_kind   <= KIND_BILINEAR;
            res_status <= STATUS_OUTSIDE;
            state      <= S_DONE;
          end else begin
            res_kind   <= {yl_val == yh_val, xl_val == xh_val};
            res_status <= STATUS_OK;
            if (xl_val == xh_val) begin
              fx_h <= 16'd0;
              fx_l <= 16'd1;
              fx_d <= 16'd1;
            end else begin
              fx_h <= xa[15:0];
              fx_l <= xb[15:0];
              fx_d <= xd[15:0];
            end
            if (yl_val == yh_val) begin
              fy_h <= 16'd0;
              fy_l <= 16'd1;
              fy_d <= 16'd1;
            end else begin
              fy_h <= ya[15:0];
              fy_l <= yb[15:0];
              fy_d <= yd[15:0];
            end
            state <= S_FETCH;
          end
        end

        // Four corner reads, data returned in the cycle after its address
        S_FETCH: begin
          if (step_cnt != 3'd0) begin
            corner[2'(step_cnt - 3'd1)] <= signed'(g_rdata);
          end
          if (step_cnt == 3'd4) begin
            step_cnt <= '0;
            state    <= S_MAC;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end

        // weight multiply, sample multiply, accumulate
        S_MAC: begin
          if (step_cnt < 3'd4) begin
            w     <= {16'b0, fa} * {16'b0, fb};
            s_reg <= corner[step_cnt[1:0]];
          end
          if (step_cnt == 3'd0) begin
            den <= {16'b0, fx_d} * {16'b0, fy_d};
            acc <= '0;
          end
          if ((step_cnt >= 3'd1) && (step_cnt <= 3'd4)) begin
            prod <= signed'({1'b0, w}) * s_reg;
          end
          if ((step_cnt >= 3'd2) && (step_cnt <= 3'd5)) begin
            acc <= acc + NUM_W'(prod);
          end
          if (step_cnt == 3'd6) begin
            neg     <= acc[NUM_W-1];
            dvd     <= acc_mag;
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end

        // Restoring division of the magnitude, one bit a cycle
        S_DIV: begin
          if (div_cnt < DCNT_W'(NUM_W)) begin
            div_cnt <= div_cnt + 1'b1;
            if (rem_sh >= {1'b0, den}) begin
              rem <= DEN_W'(rem_sh - {1'b0, den});
              dvd <= {dvd[NUM_W-2:0], 1'b1};
            end else begin
              rem <= rem_sh[DEN_W-1:0];
              dvd <= {dvd[NUM_W-2:0], 1'b0};
            end
          end else begin
            if (!neg) begin
              res_value <= (dvd > NUM_W'(32767)) ? 16'sh7fff : signed'(dvd[15:0]);
            end else begin
              res_value <= (dvd > NUM_W'(32768)) ? 16'sh8000 : signed'(-dvd[15:0]);
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_out) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == S_DONE) begin
        o_value  <= res_value;
        o_kind   <= res_kind;
        o_status <= res_status;
      end else begin
        o_value  <= '0;
        o_kind   <= KIND_BILINEAR;
        o_status <= STATUS_OK;
      end
    end
  end

  `PPBR_ASSERT(a_div_den_nonzero, (state == S_DIV) |-> (den != '0), "divide by zero area")
  `PPBR_ASSERT(a_x_low, (state == S_SETUP && xl_ok) |-> (xl_ext <= px), "x low above point")
  `PPBR_ASSERT(a_x_high, (state == S_SETUP && xh_ok) |-> (xh_ext >= px), "x high below point")
  `PPBR_ASSERT(a_result_source, $rose(o_valid) |-> $past(load_out), "stray result")

endmodule
